@@ hw/rtl/qvr_pkg.sv @@
package qvr_pkg;

    // Number of register stages from the input beat to the output register.
    localparam int unsigned PIPE_STAGES = 6;

    typedef logic [PIPE_STAGES-1:0] stage_vld_t;

    // Width of a field group once it is padded up to whole bytes.
    function automatic int unsigned bytes_up(input int unsigned bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

@@ hw/rtl/quaternion_vector_rotate.sv @@
// Channel   Beat fields (lowest bits first)                         Handshake
// s_        tdata: point_x, point_y, point_z, rot_s, rot_x, rot_y,  s_tvalid/s_tready
//           rot_z, zero padding to a byte boundary
// m_        tdata: out_x, out_y, out_z, zero padding                m_tvalid/m_tready
//           tuser: saturated
//
// An accepted input beat passes through the six register stages of the datapath:
// quaternion products, rotation matrix, split coefficient-times-point
// products, row sums, rounded accumulation, and the shift and clamp stage. One beat
// can enter in every cycle unless the output register stalls.
// All stages advance together; they hold only while the output register holds a beat
// that the sink does not take. Reset (aresetn low, synchronous) clears the valid bits.
module quaternion_vector_rotate #(
    parameter int COORD_BITS     = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                                        s_tvalid,
    output logic                                                        s_tready,
    // point_x, point_y, point_z, rot_s, rot_x, rot_y, rot_z, zero padding
    input  logic [qvr_pkg::bytes_up(3*COORD_BITS + 4*(QUAT_FRAC_BITS+2))-1:0] s_tdata,

    output logic                                                        m_tvalid,
    input  logic                                                        m_tready,
    // out_x, out_y, out_z, zero padding
    output logic [qvr_pkg::bytes_up(3*COORD_BITS)-1:0]                  m_tdata,
    // saturated
    output logic                                                        m_tuser
);

    localparam int CB   = COORD_BITS;
    localparam int F    = QUAT_FRAC_BITS;
    localparam int QB   = F + 2;            // quaternion component width
    localparam int PW   = 2 * QB;           // component product width
    localparam int MW   = 2 * QB + 2;       // rotation matrix coefficient width
    localparam int LB   = QB + 1;           // low slice of a coefficient, unsigned
    localparam int HB   = MW - LB;          // high slice of a coefficient, signed
    localparam int PHW  = HB + CB;          // high slice times coordinate
    localparam int PLW  = LB + 1 + CB;      // low slice times coordinate
    localparam int HSW  = PHW + 2;          // sum of three high products
    localparam int LSW  = PLW + 2;          // sum of three low products
    localparam int AW   = 2 * QB + CB + 3;  // full precision coordinate
    localparam int RW   = AW - 2 * F;       // coordinate after the fraction shift
    localparam int SW   = qvr_pkg::bytes_up(3*CB + 4*QB);
    localparam int OW   = qvr_pkg::bytes_up(3*CB);
    localparam int LAST = qvr_pkg::PIPE_STAGES - 1;

    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (2*F - 1);

    // Stall control: every stage moves when the output register can take a beat.
    qvr_pkg::stage_vld_t vld_reg;
    logic                adv;

    assign adv      = !vld_reg[LAST] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
        end
    end

    // Input fields.
    logic signed [CB-1:0] in_p [3];
    logic signed [QB-1:0] rs, rx, ry, rz;

    assign in_p[0] = $signed(s_tdata[CB-1:0]);
    assign in_p[1] = $signed(s_tdata[2*CB-1:CB]);
    assign in_p[2] = $signed(s_tdata[3*CB-1:2*CB]);
    assign rs      = $signed(s_tdata[3*CB      +: QB]);
    assign rx      = $signed(s_tdata[3*CB+QB   +: QB]);
    assign ry      = $signed(s_tdata[3*CB+2*QB +: QB]);
    assign rz      = $signed(s_tdata[3*CB+3*QB +: QB]);

    // Stage 1: the ten distinct products of quaternion components.
    logic signed [PW-1:0] ss_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [PW-1:0] xz_reg, yz_reg, sx_reg, sy_reg, sz_reg;
    logic signed [CB-1:0] p1_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            ss_reg <= PW'(rs) * PW'(rs);
            xx_reg <= PW'(rx) * PW'(rx);
            yy_reg <= PW'(ry) * PW'(ry);
            zz_reg <= PW'(rz) * PW'(rz);
            xy_reg <= PW'(rx) * PW'(ry);
            xz_reg <= PW'(rx) * PW'(rz);
            yz_reg <= PW'(ry) * PW'(rz);
            sx_reg <= PW'(rs) * PW'(rx);
            sy_reg <= PW'(rs) * PW'(ry);
            sz_reg <= PW'(rs) * PW'(rz);
            p1_reg <= in_p;
        end
    end

    // Stage 2: the rotation matrix, row major. Non-unit quaternions are not
    // normalized, so the matrix carries the squared norm as a scale.
    logic signed [MW-1:0] coef_next [9];
    logic signed [MW-1:0] coef_reg  [9];
    logic signed [CB-1:0] p2_reg    [3];

    always_comb begin
        coef_next[0] = MW'(ss_reg) + MW'(xx_reg) - MW'(yy_reg) - MW'(zz_reg);
        coef_next[1] = (MW'(xy_reg) - MW'(sz_reg)) <<< 1;
        coef_next[2] = (MW'(xz_reg) + MW'(sy_reg)) <<< 1;
        coef_next[3] = (MW'(xy_reg) + MW'(sz_reg)) <<< 1;
        coef_next[4] = MW'(ss_reg) - MW'(xx_reg) + MW'(yy_reg) - MW'(zz_reg);
        coef_next[5] = (MW'(yz_reg) - MW'(sx_reg)) <<< 1;
        coef_next[6] = (MW'(xz_reg) - MW'(sy_reg)) <<< 1;
        coef_next[7] = (MW'(yz_reg) + MW'(sx_reg)) <<< 1;
        coef_next[8] = MW'(ss_reg) - MW'(xx_reg) - MW'(yy_reg) + MW'(zz_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            coef_reg <= coef_next;
            p2_reg   <= p1_reg;
        end
    end

    // Stage 3: each coefficient is split into a signed high slice and an unsigned
    // low slice so that every multiplier stays near the width of one coordinate.
    logic signed [PHW-1:0] phi_reg [9];
    logic signed [PLW-1:0] plo_reg [9];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                phi_reg[k] <= PHW'($signed(coef_reg[k][MW-1:LB])) * PHW'(p2_reg[k % 3]);
                plo_reg[k] <= PLW'($signed({1'b0, coef_reg[k][LB-1:0]}))
                              * PLW'(p2_reg[k % 3]);
            end
        end
    end

    // Stage 4: per output coordinate, sum the high and the low products.
    logic signed [HSW-1:0] hs_reg [3];
    logic signed [LSW-1:0] ls_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                hs_reg[r] <= HSW'(phi_reg[3*r]) + HSW'(phi_reg[3*r+1])
                             + HSW'(phi_reg[3*r+2]);
                ls_reg[r] <= LSW'(plo_reg[3*r]) + LSW'(plo_reg[3*r+1])
                             + LSW'(plo_reg[3*r+2]);
            end
        end
    end

    // Stage 5: exact coordinate plus one half of the output step, so that the
    // shift below rounds to nearest with ties toward positive infinity.
    logic signed [AW-1:0] acc_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                acc_reg[r] <= (AW'(hs_reg[r]) <<< LB) + AW'(ls_reg[r]) + ROUND_HALF;
            end
        end
    end

    // Stage 6: drop the fraction and clamp to the coordinate range.
    logic [RW-1:0] shifted [3];
    logic [CB-1:0] coord_next [3];
    logic [2:0]    clamp;
    logic [CB-1:0] coord_reg [3];
    logic          sat_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            shifted[r] = acc_reg[r][AW-1:2*F];
            clamp[r]   = 1'b0;
            if (!shifted[r][RW-1] && (shifted[r][RW-2:CB-1] != '0)) begin
                clamp[r]      = 1'b1;
                coord_next[r] = {1'b0, {(CB-1){1'b1}}};
            end else if (shifted[r][RW-1] && (shifted[r][RW-2:CB-1] != '1)) begin
                clamp[r]      = 1'b1;
                coord_next[r] = {1'b1, {(CB-1){1'b0}}};
            end else begin
                coord_next[r] = shifted[r][CB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            coord_reg <= coord_next;
            sat_reg   <= |clamp;
        end
    end

    assign m_tdata = OW'({coord_reg[2], coord_reg[1], coord_reg[0]});
    assign m_tuser = sat_reg;

endmodule

@@ hw/rtl/qvr_checker.sv @@
module qvr_checker #(
    parameter int COORD_BITS     = 16
) (
    input logic                                        aclk,
    input logic                                        aresetn,
    input logic                                        s_tready,
    input logic                                        m_tvalid,
    input logic                                        m_tready,
    input logic [qvr_pkg::bytes_up(3*COORD_BITS)-1:0]  m_tdata,
    input logic                                        m_tuser
);

    localparam int CB = COORD_BITS;
    localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    logic [CB-1:0] ox, oy, oz;

    assign ox = m_tdata[CB-1:0];
    assign oy = m_tdata[2*CB-1:CB];
    assign oz = m_tdata[3*CB-1:2*CB];

    // A held output beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // The input side stalls only behind a full, untaken output register.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output stall");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A saturated beat carries at least one clamped coordinate.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (ox == CMAX) || (ox == CMIN) || (oy == CMAX)
                                || (oy == CMIN) || (oz == CMAX) || (oz == CMIN))
        else $error("saturated flag without a clamped coordinate");

endmodule

bind quaternion_vector_rotate qvr_checker #(
    .COORD_BITS     (COORD_BITS)
) u_qvr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ bench/tb.sv @@
module tb;

    localparam int COORD_W  = 16;
    localparam int IN_W     = qvr_pkg::bytes_up(3*COORD_W + 4*16);
    localparam int OUT_W    = qvr_pkg::bytes_up(3*COORD_W);
    localparam int RAND_PER_PHASE = 650;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 100000;
    localparam longint COORD_MAX = 32767;
    localparam longint COORD_MIN = -32768;

    // One input beat, point_x in the lowest bits.
    typedef struct packed {
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_s;
        logic signed [15:0] point_z;
        logic signed [15:0] point_y;
        logic signed [15:0] point_x;
    } rot_beat_t;

    // One rotated point as it is carried on m_tdata, out_x in the lowest bits.
    typedef struct packed {
        logic signed [15:0] out_z;
        logic signed [15:0] out_y;
        logic signed [15:0] out_x;
    } rot_coords_t;

    typedef struct packed {
        logic        saturated;
        rot_coords_t coords;
    } rot_result_t;

    // Holds the rotations still in flight and checks each output beat against the oldest.
    class rotation_scoreboard;
        rot_result_t pending[$];
        int unsigned mismatches = 0;

        // Full-precision q * (0, P) * conj(q), rounded half up after the 28-bit shift
        // and clamped to 16 bits. All partial sums stay well inside 64 bits.
        function rot_result_t rotate_point(rot_beat_t b);
            longint s, x, y, z, px, py, pz, v;
            longint acc[3];
            logic signed [15:0] c[3];
            rot_result_t r;
            s  = b.rot_s;
            x  = b.rot_x;
            y  = b.rot_y;
            z  = b.rot_z;
            px = b.point_x;
            py = b.point_y;
            pz = b.point_z;
            acc[0] = (s*s + x*x - y*y - z*z)*px + 2*(x*y - s*z)*py + 2*(x*z + s*y)*pz;
            acc[1] = 2*(x*y + s*z)*px + (s*s - x*x + y*y - z*z)*py + 2*(y*z - s*x)*pz;
            acc[2] = 2*(x*z - s*y)*px + 2*(y*z + s*x)*py + (s*s - x*x - y*y + z*z)*pz;
            r.saturated = 1'b0;
            for (int i = 0; i < 3; i++) begin
                v = (acc[i] + (64'sd1 <<< 27)) >>> 28;
                if (v > COORD_MAX) begin
                    v = COORD_MAX;
                    r.saturated = 1'b1;
                end else if (v < COORD_MIN) begin
                    v = COORD_MIN;
                    r.saturated = 1'b1;
                end
                c[i] = v[15:0];
            end
            r.coords.out_x = c[0];
            r.coords.out_y = c[1];
            r.coords.out_z = c[2];
            return r;
        endfunction

        function void note_input(rot_beat_t b);
            pending.push_back(rotate_point(b));
        endfunction

        function void check_result(rot_coords_t got, logic got_sat);
            rot_result_t want;
            if (pending.size() == 0) begin
                $error("output beat with no rotation pending: x=%0d y=%0d z=%0d",
                       got.out_x, got.out_y, got.out_z);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.out_x !== want.coords.out_x) begin
                $error("out_x: expected %0d, got %0d", want.coords.out_x, got.out_x);
                mismatches++;
            end
            if (got.out_y !== want.coords.out_y) begin
                $error("out_y: expected %0d, got %0d", want.coords.out_y, got.out_y);
                mismatches++;
            end
            if (got.out_z !== want.coords.out_z) begin
                $error("out_z: expected %0d, got %0d", want.coords.out_z, got.out_z);
                mismatches++;
            end
            if (got_sat !== want.saturated) begin
                $error("saturated: expected %0b, got %0b", want.saturated, got_sat);
                mismatches++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;

    // Idle rates in percent for each side, and the receiver's pending hold-off.
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_left     = 0;
    longint cycle_count   = 0;

    rotation_scoreboard rot_sb = new();

    quaternion_vector_rotate u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Both channels are observed at the rising edge, where the handshake takes place.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            rot_sb.note_input(rot_beat_t'(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            rot_sb.check_result(rot_coords_t'(m_tdata[3*COORD_W-1:0]), m_tuser);
        end
    end

    // The sink. A requested hold-off is counted down here, one cycle per falling edge,
    // and keeps tready low the whole time regardless of the idle rate.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one beat, with random idle cycles ahead of it, and returns once it is taken.
    task automatic send_beat(input rot_beat_t b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(b);
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic rot_beat_t make_beat(input int px, input int py, input int pz,
                                            input int qs, input int qx, input int qy,
                                            input int qz);
        rot_beat_t b;
        b.point_x = 16'(px);
        b.point_y = 16'(py);
        b.point_z = 16'(pz);
        b.rot_s   = 16'(qs);
        b.rot_x   = 16'(qx);
        b.rot_y   = 16'(qy);
        b.rot_z   = 16'(qz);
        return b;
    endfunction

    // A field value drawn from the full range, near zero, or from the edge codes.
    function automatic logic signed [15:0] pick_field();
        case ($urandom_range(3))
            0: return 16'(int'($urandom_range(127)) - 64);
            1: begin
                case ($urandom_range(4))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    3: return 16'shffff;
                    default: return 16'sh0001;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Most beats carry a unit quaternion so that the rotation itself is exercised
    // without norm scaling; the rest use raw or edge-heavy quaternions.
    function automatic rot_beat_t random_beat();
        rot_beat_t b;
        real a, c, d, e, n;
        b.point_x = ($urandom_range(3) == 0) ? pick_field() : 16'($urandom);
        b.point_y = ($urandom_range(3) == 0) ? pick_field() : 16'($urandom);
        b.point_z = ($urandom_range(3) == 0) ? pick_field() : 16'($urandom);
        if ($urandom_range(9) < 6) begin
            a = real'($urandom_range(65535)) - 32768.0;
            c = real'($urandom_range(65535)) - 32768.0;
            d = real'($urandom_range(65535)) - 32768.0;
            e = real'($urandom_range(65535)) - 32768.0;
            n = $sqrt(a*a + c*c + d*d + e*e);
            if (n < 1.0) n = 1.0;
            b.rot_s = 16'($rtoi(a * 16384.0 / n));
            b.rot_x = 16'($rtoi(c * 16384.0 / n));
            b.rot_y = 16'($rtoi(d * 16384.0 / n));
            b.rot_z = 16'($rtoi(e * 16384.0 / n));
        end else if ($urandom_range(1) == 0) begin
            b.rot_s = pick_field();
            b.rot_x = pick_field();
            b.rot_y = pick_field();
            b.rot_z = pick_field();
        end else begin
            b.rot_s = 16'($urandom);
            b.rot_x = 16'($urandom);
            b.rot_y = 16'($urandom);
            b.rot_z = 16'($urandom);
        end
        return b;
    endfunction

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 58;

        // All zero, then the identity rotation on an ordinary point and on both corners.
        send_beat(make_beat(0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(1000, -2000, 3000, 16384, 0, 0, 0));
        send_beat(make_beat(32767, 32767, 32767, 16384, 0, 0, 0));
        send_beat(make_beat(-32768, -32768, -32768, 16384, 0, 0, 0));
        send_beat(make_beat(-1, 0, 1, -16384, 0, 0, 0));
        // Quarter turn about z and half turn about x.
        send_beat(make_beat(10000, 0, 0, 11585, 0, 0, 11585));
        send_beat(make_beat(100, 200, 300, 0, 16384, 0, 0));
        // Non-unit quaternion: the point comes out scaled by the squared norm.
        send_beat(make_beat(1000, 1000, 1000, 32767, 0, 0, 0));
        // Exact halves: +0.5 rounds up to 1, -0.5 rounds up to 0, 1.5 to 2.
        send_beat(make_beat(2, -2, 6, 8192, 0, 0, 0));
        // Clamping on some coordinates only, high and low.
        send_beat(make_beat(16000, 100, -16000, 32767, 0, 0, 0));
        send_beat(make_beat(32767, -32768, 0, 0, 0, 0, -32768));
        // Most negative codes everywhere are plain values; large sums must not wrap.
        send_beat(make_beat(1, 1, 1, -32768, -32768, -32768, -32768));
        send_beat(make_beat(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_beat(make_beat(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_beat(make_beat(-32768, 32767, -32768, 32767, -32768, 32767, -32768));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // The sink stops for a long stretch while beats keep coming, so the
                    // pipeline fills up and has to push back on the input.
                    hold_left = HOLD_OFF_CYCLES;
                end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                send_beat(random_beat());
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (rot_sb.pending.size() != 0) @(posedge aclk);
        // Keep watching past the pipeline depth so that any stray extra beat would still be seen.
        repeat (qvr_pkg::PIPE_STAGES + 4) @(posedge aclk);

        if (rot_sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
